FILE: hdl/dotq_pkg.sv
// ----------------------------------------------------------------------------
// dotq_pkg: shared types and constants for the deadline ordered timer queue
// Request codes, transaction payload structs and the front/back command type.
// ----------------------------------------------------------------------------
package dotq_pkg;

  typedef enum logic [2:0] {
    REQ_ADD    = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_TICK   = 3'd2,
    REQ_IDLE   = 3'd3,
    REQ_TASKS  = 3'd4,
    REQ_STOP   = 3'd5
  } req_e;

  localparam logic [31:0] NowReset = 32'hFFFF_8000;
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned Slots    = 16;
  localparam int unsigned IdW      = 4;
  localparam int unsigned LenW     = 5;
  localparam logic [0:0]  RegTick  = 1'b0;

  typedef struct packed {
    logic [2:0]     req_type;
    logic [IdW-1:0] event_id;
    logic [30:0]    delay;
    logic [15:0]    task_count;
  } req_t;

  typedef struct packed {
    logic           accepted;
    logic           fired_valid;
    logic [IdW-1:0] fired_id;
    logic           last;
    logic           running;
    logic [31:0]    current_time;
  } rsp_t;

  typedef struct packed {
    logic [2:0]     req_type;
    logic           id_ok;
    logic [IdW-1:0] event_id;
    logic [30:0]    delay;
    logic           tasks_gt1;
  } cmd_t;

endpackage

FILE: hdl/dotq_front.sv
// ----------------------------------------------------------------------------
// dotq_front: request intake
// Classifies an accepted request and pushes it into a small command queue.
// ----------------------------------------------------------------------------
module dotq_front import dotq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  input  logic pop_i,
  output logic cmd_valid_o,
  output cmd_t cmd_o
);

  localparam int unsigned PtrW = $clog2(CmdDepth);

  cmd_t              fifo_q [CmdDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;
  logic              push;
  cmd_t              cmd_in;

  // busy only while the command queue is full
  assign busy_o      = (cnt_q == (PtrW+1)'(CmdDepth));
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = fifo_q[rd_q];

  always_comb begin
    cmd_in.req_type  = req_i.req_type;
    cmd_in.id_ok     = ({28'd0, req_i.event_id} < 32'(Slots));
    cmd_in.event_id  = req_i.event_id;
    cmd_in.delay     = req_i.delay;
    cmd_in.tasks_gt1 = (req_i.task_count > 16'd1);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/dotq_back.sv
// ----------------------------------------------------------------------------
// dotq_back: list engine
// Walks the deadline sorted list one entry per cycle for insert, delete and
// tick, and emits result transactions.
// ----------------------------------------------------------------------------
module dotq_back import dotq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] tick_interval_i,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        pop_o,
  output logic        push_o,
  output logic        done_o,
  output rsp_t        rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE, ST_ADD, ST_DEL, ST_TICK
  } state_e;

  state_e            state_q;
  logic [31:0]       now_q;
  logic              run_q;
  logic [31:0]       dl_q   [Slots];
  logic [IdW-1:0]    ord_q  [Slots];
  logic [Slots-1:0]  queued_q;
  logic [LenW-1:0]   len_q;
  logic [LenW-1:0]   idx_q;
  logic [IdW-1:0]    id_q;
  logic [31:0]       when_q;

  logic [IdW-1:0]    scan_id, head_id;
  logic [31:0]       scan_diff, head_diff;
  logic              add_hit, head_due;

  function automatic rsp_t mk_rsp(logic acc, logic fv, logic [IdW-1:0] fid,
                                  logic lst, logic run, logic [31:0] t);
    rsp_t r;
    r.accepted     = acc;
    r.fired_valid  = fv;
    r.fired_id     = fid;
    r.last         = lst;
    r.running      = run;
    r.current_time = t;
    return r;
  endfunction

  assign pop_o     = cmd_valid_i && (state_q == ST_IDLE);

  assign scan_id   = ord_q[idx_q[IdW-1:0]];
  assign scan_diff = when_q - dl_q[scan_id];
  // listed entry at or after the new deadline
  assign add_hit   = (scan_diff == '0) || scan_diff[31];
  assign head_id   = ord_q[0];
  assign head_diff = now_q - dl_q[head_id];
  assign head_due  = (len_q != '0) && !head_diff[31];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      now_q    <= NowReset;
      run_q    <= 1'b0;
      queued_q <= '0;
      len_q    <= '0;
      idx_q    <= '0;
      id_q     <= '0;
      when_q   <= '0;
      push_o   <= 1'b0;
      done_o   <= 1'b0;
      rsp_o    <= '0;
      for (int i = 0; i < Slots; i++) begin
        dl_q[i]  <= '0;
        ord_q[i] <= '0;
      end
    end else begin
      push_o <= 1'b0;
      done_o <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            id_q  <= cmd_i.event_id;
            idx_q <= '0;
            case (cmd_i.req_type)
              REQ_ADD: begin
                if (!cmd_i.id_ok || queued_q[cmd_i.event_id] ||
                    len_q == LenW'(Slots)) begin
                  done_o <= 1'b1;
                  rsp_o  <= mk_rsp(1'b0, 1'b0, '0, 1'b1, run_q, now_q);
                end else begin
                  when_q  <= now_q + {1'b0, cmd_i.delay};
                  state_q <= ST_ADD;
                end
              end
              REQ_DELETE: begin
                if (cmd_i.id_ok && queued_q[cmd_i.event_id]) begin
                  state_q <= ST_DEL;
                end else begin
                  done_o <= 1'b1;
                  rsp_o  <= mk_rsp(1'b1, 1'b0, '0, 1'b1, run_q, now_q);
                end
              end
              REQ_TICK: begin
                now_q   <= now_q + {16'd0, tick_interval_i};
                state_q <= ST_TICK;
              end
              REQ_IDLE: begin
                done_o <= 1'b1;
                run_q  <= run_q && (len_q != '0);
                rsp_o  <= mk_rsp(1'b0, 1'b0, '0, 1'b1, run_q && (len_q != '0), now_q);
              end
              REQ_TASKS: begin
                done_o <= 1'b1;
                run_q  <= run_q || cmd_i.tasks_gt1;
                rsp_o  <= mk_rsp(1'b0, 1'b0, '0, 1'b1, run_q || cmd_i.tasks_gt1, now_q);
              end
              REQ_STOP: begin
                done_o <= 1'b1;
                run_q  <= 1'b0;
                rsp_o  <= mk_rsp(1'b0, 1'b0, '0, 1'b1, 1'b0, now_q);
              end
              default: begin
                done_o <= 1'b1;
                rsp_o  <= mk_rsp(1'b0, 1'b0, '0, 1'b1, run_q, now_q);
              end
            endcase
          end
        end
        ST_ADD: begin
          // scan from the head for the insert position, then shift in one go
          if (add_hit || idx_q == len_q) begin
            for (int i = 0; i < Slots; i++) begin
              if (LenW'(i) == idx_q) begin
                ord_q[i] <= id_q;
              end else if (LenW'(i) > idx_q) begin
                ord_q[i] <= ord_q[IdW'(i - 1)];
              end
            end
            dl_q[id_q]     <= when_q;
            queued_q[id_q] <= 1'b1;
            len_q          <= len_q + 1'b1;
            run_q          <= 1'b1;
            done_o         <= 1'b1;
            rsp_o          <= mk_rsp(1'b1, 1'b0, '0, 1'b1, 1'b1, now_q);
            state_q        <= ST_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_DEL: begin
          if (scan_id == id_q) begin
            for (int i = 0; i < Slots - 1; i++) begin
              if (LenW'(i) >= idx_q) ord_q[i] <= ord_q[i + 1];
            end
            len_q          <= len_q - 1'b1;
            queued_q[id_q] <= 1'b0;
            done_o         <= 1'b1;
            rsp_o          <= mk_rsp(1'b1, 1'b0, '0, 1'b1, run_q, now_q);
            state_q        <= ST_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_TICK: begin
          if (head_due) begin
            for (int i = 0; i < Slots - 1; i++) begin
              ord_q[i] <= ord_q[i + 1];
            end
            queued_q[head_id] <= 1'b0;
            len_q  <= len_q - 1'b1;
            push_o <= 1'b1;
            rsp_o  <= mk_rsp(1'b0, 1'b1, head_id, 1'b0, run_q, now_q);
          end else begin
            done_o  <= 1'b1;
            rsp_o   <= mk_rsp(1'b0, 1'b0, '0, 1'b1, run_q, now_q);
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/dotq_out.sv
// ----------------------------------------------------------------------------
// dotq_out: result stage
// Delays tick results by one slot so the final transaction carries last.
// ----------------------------------------------------------------------------
module dotq_out import dotq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  logic done_i,
  input  rsp_t rsp_i,
  output logic valid_o,
  output rsp_t rsp_o
);

  logic hold_v_q;
  rsp_t hold_q;
  rsp_t hold_last;

  always_comb begin
    hold_last      = hold_q;
    hold_last.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      valid_o  <= 1'b0;
      hold_q   <= '0;
      rsp_o    <= '0;
    end else begin
      if (push_i) begin
        valid_o  <= hold_v_q;
        rsp_o    <= hold_q;
        hold_q   <= rsp_i;
        hold_v_q <= 1'b1;
      end else if (done_i) begin
        valid_o  <= 1'b1;
        hold_v_q <= 1'b0;
        rsp_o    <= hold_v_q ? hold_last : rsp_i;
      end else begin
        valid_o  <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/deadline_ordered_timer_queue.sv
// ----------------------------------------------------------------------------
// deadline_ordered_timer_queue: sorted timer event queue
// Requests pass through the command queue, the list engine and the result stage;
// add and delete walk the list one entry per cycle.
// A two-entry command queue takes requests while the list engine works; busy
// only when it is full. The receiver cannot stall results.
// Reset: time = -32768, timer stopped, list empty, tick interval 0.
// ----------------------------------------------------------------------------
module deadline_ordered_timer_queue import dotq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        strobe,
  output rsp_t        rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] tick_q;
  logic        pop, cmd_valid, push, done;
  cmd_t        cmd;
  rsp_t        brsp;

  assign pready = 1'b1;
  assign prdata = (paddr == RegTick) ? {16'd0, tick_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
    end else if (psel && penable && pwrite && paddr == RegTick) begin
      tick_q <= pwdata[15:0];
    end
  end

  dotq_front u_front (
    .clk_i, .rst_ni, .start_i(start), .req_i, .busy_o(busy),
    .pop_i(pop), .cmd_valid_o(cmd_valid), .cmd_o(cmd)
  );

  dotq_back u_back (
    .clk_i, .rst_ni, .tick_interval_i(tick_q), .cmd_valid_i(cmd_valid),
    .cmd_i(cmd), .pop_o(pop), .push_o(push), .done_o(done), .rsp_o(brsp)
  );

  dotq_out u_out (
    .clk_i, .rst_ni, .push_i(push), .done_i(done), .rsp_i(brsp),
    .valid_o(strobe), .rsp_o
  );

endmodule
